/* rtl/quaternion_point_rotation_core_macros.svh */
// Assertion macros for the quaternion point rotation core.
`ifndef QUATERNION_POINT_ROTATION_CORE_MACROS_SVH
`define QUATERNION_POINT_ROTATION_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define QPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define QPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/qpr_pkg.sv */
// Types, constants and helpers for the quaternion point rotation core.
`timescale 1ns / 1ps
`default_nettype none
package qpr_pkg;

  localparam int COORD_W   = 24;
  localparam int QUAT_W    = 16;
  localparam int PROD1_W   = COORD_W + QUAT_W;     // q * p
  localparam int TVEC_W    = PROD1_W + 2;          // sum of three products
  localparam int PROD2_W   = TVEC_W + QUAT_W;      // q * t
  localparam int UVEC_W    = PROD2_W + 2;          // sum of four products
  localparam int RND_SHIFT = 30;
  localparam int RES_W     = UVEC_W - RND_SHIFT;
  localparam int NUM_STG   = 5;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [TVEC_W-1:0]  tvec_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [UVEC_W-1:0]  uvec_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_S = 2'd0,
    REG_X = 2'd1,
    REG_Y = 2'd2,
    REG_Z = 2'd3
  } cfg_reg_t;

  // quaternion component index
  localparam int QS = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;
  // vertex coordinate index
  localparam int PX = 0;
  localparam int PY = 1;
  localparam int PZ = 2;

  localparam quat_t  QUAT_S_RST = quat_t'(16'sh7FFF);
  localparam coord_t COORD_MAX  = coord_t'(24'sh7FFFFF);
  localparam coord_t COORD_MIN  = coord_t'(24'sh800000);
  localparam uvec_t  RND_HALF   = uvec_t'(1) <<< (RND_SHIFT - 1);

  typedef struct packed {
    coord_t val;
    logic   clip;
  } sat_t;

  // round to nearest (ties up) at scale 2^8, then clamp to 24 bits
  function automatic sat_t round_sat(input uvec_t v);
    uvec_t rnd;
    res_t  r;
    sat_t  o;
    rnd = v + RND_HALF;
    r   = res_t'(rnd[UVEC_W-1:RND_SHIFT]);
    if (r > res_t'(COORD_MAX)) begin
      o.val  = COORD_MAX;
      o.clip = 1'b1;
    end else if (r < res_t'(COORD_MIN)) begin
      o.val  = COORD_MIN;
      o.clip = 1'b1;
    end else begin
      o.val  = r[COORD_W-1:0];
      o.clip = 1'b0;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/quaternion_point_rotation_core.sv */
// Top level: pipelined quaternion sandwich rotation of Q15.8 vertices.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------
//   in      | in  | in_valid / in_ready  | px, py, pz
//   out     | out | out_valid / out_ready| rx, ry, rz, clipped
//   cfg     | in  | cfg_we               | cfg_idx, cfg_data
//
// Five register stages: q*p products, t sums, q*t products, u sums, round/clamp.
// One transaction per clock when out_ready stays high.
// A stage loads whenever it is empty or the stage after it moves, so stalls
// close bubbles and lose nothing. rst (synchronous) clears the valid bits and
// sets the quaternion to (32767, 0, 0, 0).
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_point_rotation_core_macros.svh"
module quaternion_point_rotation_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qpr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [qpr_pkg::QUAT_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qpr_pkg::coord_t                  px,
  input  qpr_pkg::coord_t                  py,
  input  qpr_pkg::coord_t                  pz,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qpr_pkg::coord_t                  rx,
  output qpr_pkg::coord_t                  ry,
  output qpr_pkg::coord_t                  rz,
  output logic                             clipped
);
  import qpr_pkg::*;

  quat_t  quat [4];
  coord_t pv   [3];

  logic [NUM_STG-1:0] vld;
  logic [NUM_STG-1:0] rdy;

  prod1_t m1 [4][3];
  tvec_t  t  [4];
  prod2_t m2 [3][4];
  uvec_t  u  [3];

  sat_t sx, sy, sz;

  assign pv[PX] = px;
  assign pv[PY] = py;
  assign pv[PZ] = pz;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quat[QS] <= QUAT_S_RST;
      quat[QX] <= '0;
      quat[QY] <= '0;
      quat[QZ] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_S: quat[QS] <= quat_t'(cfg_data);
        REG_X: quat[QX] <= quat_t'(cfg_data);
        REG_Y: quat[QY] <= quat_t'(cfg_data);
        REG_Z: quat[QZ] <= quat_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // ready chain, back to front
  always_comb begin
    rdy[NUM_STG-1] = !vld[NUM_STG-1] || out_ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NUM_STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: q * p products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int qi = 0; qi < 4; qi++) begin
        for (int pi = 0; pi < 3; pi++) begin
          m1[qi][pi] <= prod1_t'(quat[qi]) * prod1_t'(pv[pi]);
        end
      end
    end
  end

  // stage 2: t = q * (0, p)
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t[QS] <= tvec_t'(0) - tvec_t'(m1[QX][PX]) - tvec_t'(m1[QY][PY])
               - tvec_t'(m1[QZ][PZ]);
      t[QX] <= tvec_t'(m1[QS][PX]) + tvec_t'(m1[QY][PZ]) - tvec_t'(m1[QZ][PY]);
      t[QY] <= tvec_t'(m1[QS][PY]) + tvec_t'(m1[QZ][PX]) - tvec_t'(m1[QX][PZ]);
      t[QZ] <= tvec_t'(m1[QS][PZ]) + tvec_t'(m1[QX][PY]) - tvec_t'(m1[QY][PX]);
    end
  end

  // stage 3: q * t products, grouped per output coordinate (+ - - +)
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      m2[PX][0] <= prod2_t'(quat[QS]) * prod2_t'(t[QX]);
      m2[PX][1] <= prod2_t'(quat[QX]) * prod2_t'(t[QS]);
      m2[PX][2] <= prod2_t'(quat[QZ]) * prod2_t'(t[QY]);
      m2[PX][3] <= prod2_t'(quat[QY]) * prod2_t'(t[QZ]);
      m2[PY][0] <= prod2_t'(quat[QS]) * prod2_t'(t[QY]);
      m2[PY][1] <= prod2_t'(quat[QY]) * prod2_t'(t[QS]);
      m2[PY][2] <= prod2_t'(quat[QX]) * prod2_t'(t[QZ]);
      m2[PY][3] <= prod2_t'(quat[QZ]) * prod2_t'(t[QX]);
      m2[PZ][0] <= prod2_t'(quat[QS]) * prod2_t'(t[QZ]);
      m2[PZ][1] <= prod2_t'(quat[QZ]) * prod2_t'(t[QS]);
      m2[PZ][2] <= prod2_t'(quat[QY]) * prod2_t'(t[QX]);
      m2[PZ][3] <= prod2_t'(quat[QX]) * prod2_t'(t[QY]);
    end
  end

  // stage 4: u = t * conj(q), vector part
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        u[k] <= uvec_t'(m2[k][0]) - uvec_t'(m2[k][1]) - uvec_t'(m2[k][2])
                + uvec_t'(m2[k][3]);
      end
    end
  end

  // stage 5: round, clamp, output register
  assign sx = round_sat(u[PX]);
  assign sy = round_sat(u[PY]);
  assign sz = round_sat(u[PZ]);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rx      <= sx.val;
      ry      <= sy.val;
      rz      <= sz.val;
      clipped <= sx.clip | sy.clip | sz.clip;
    end
  end

  `QPR_ASSERT_NOW(a_full_when_blocked, !in_ready, out_valid && !out_ready, "input blocked without output stall")
  `QPR_ASSERT_NOW(a_clip_at_limit, out_valid && clipped, rx == COORD_MAX || rx == COORD_MIN || ry == COORD_MAX || ry == COORD_MIN || rz == COORD_MAX || rz == COORD_MIN, "clipped set with no coordinate at a limit")
  `QPR_ASSERT_NEXT(a_out_from_stage4, !out_valid && !vld[NUM_STG-2], !out_valid, "output valid without a transaction in stage 4")

endmodule
`default_nettype wire

/* bench/quaternion_point_rotation_core_tb.sv */
// Testbench for quaternion_point_rotation_core: directed and random vertex rotations.
`timescale 1ns / 1ps
module quaternion_point_rotation_core_tb;
  import qpr_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clip;
  } rotated_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [QUAT_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  coord_t               px, py, pz;
  logic                 out_valid;
  logic                 out_ready;
  coord_t               rx, ry, rz;
  logic                 clipped;

  // local copy of the quaternion registers
  quat_t rot_s, rot_x, rot_y, rot_z;
  rotated_t rotated_q[$];
  int  mismatches;
  int  quiet_cycles;
  bit  idle_on;

  quaternion_point_rotation_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .px        (px),
    .py        (py),
    .pz        (pz),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rx        (rx),
    .ry        (ry),
    .rz        (rz),
    .clipped   (clipped)
  );

  always #1 clk = ~clk;

  // round to nearest, ties up, at scale 2^8; clamp to 24 bits
  function automatic coord_t round_clamp(input longint v, inout logic clip);
    longint r;
    r = (v + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > longint'(COORD_MAX)) begin
      r = longint'(COORD_MAX);
      clip = 1'b1;
    end else if (r < longint'(COORD_MIN)) begin
      r = longint'(COORD_MIN);
      clip = 1'b1;
    end
    return coord_t'(r);
  endfunction

  // q * (0, p) * conj(q), exact in 64 bits
  function automatic rotated_t rotate_vertex(input coord_t x, input coord_t y, input coord_t z);
    longint s, a, b, c, vx, vy, vz;
    longint ts, tx, ty, tz, ux, uy, uz;
    rotated_t r;
    s  = rot_s;
    a  = rot_x;
    b  = rot_y;
    c  = rot_z;
    vx = x;
    vy = y;
    vz = z;
    ts = -(a * vx + b * vy + c * vz);
    tx = s * vx + b * vz - c * vy;
    ty = s * vy + c * vx - a * vz;
    tz = s * vz + a * vy - b * vx;
    ux = s * tx - ts * a - ty * c + tz * b;
    uy = s * ty - ts * b - tz * a + tx * c;
    uz = s * tz - ts * c - tx * b + ty * a;
    r.clip = 1'b0;
    r.x = round_clamp(ux, r.clip);
    r.y = round_clamp(uy, r.clip);
    r.z = round_clamp(uz, r.clip);
    return r;
  endfunction

  function automatic coord_t rand_coord();
    int unsigned pick;
    coord_t v;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0: v = COORD_MAX;
          1: v = COORD_MIN;
          2: v = '0;
          3: v = coord_t'(-1);
          default: v = coord_t'(1);
        endcase
      end
      1, 2: v = coord_t'(int'($urandom_range(0, 2000)) - 1000);
      default: v = coord_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    px <= x;
    py <= y;
    pz <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotated_q.push_back(rotate_vertex(x, y, z));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (NUM_STG + 2) @(posedge clk);
  endtask

  // block must be idle here
  task automatic write_quaternion(input quat_t s, input quat_t x, input quat_t y,
                                  input quat_t z);
    cfg_we <= 1'b1;
    cfg_idx <= REG_S;
    cfg_data <= s;
    @(posedge clk);
    rot_s = s;
    cfg_idx <= REG_X;
    cfg_data <= x;
    @(posedge clk);
    rot_x = x;
    cfg_idx <= REG_Y;
    cfg_data <= y;
    @(posedge clk);
    rot_y = y;
    cfg_idx <= REG_Z;
    cfg_data <= z;
    @(posedge clk);
    rot_z = z;
    cfg_we <= 1'b0;
  endtask

  // unit quaternion for a random angle about a random axis
  task automatic write_random_rotation();
    real deg, half, ax, ay, az, norm, sn;
    deg  = $urandom_range(0, 71999) / 100.0;
    half = -deg * 3.14159265359 / 180.0 / 2.0;
    ax   = $urandom_range(0, 2000) - 1000.0;
    ay   = $urandom_range(0, 2000) - 1000.0;
    az   = $urandom_range(0, 2000) - 1000.0;
    norm = $sqrt(ax * ax + ay * ay + az * az);
    if (norm < 1.0) begin
      ax   = 1.0;
      norm = 1.0;
    end
    sn = $sin(half) * 32767.0 / norm;
    write_quaternion(quat_t'($rtoi($cos(half) * 32767.0)), quat_t'($rtoi(sn * ax)),
                     quat_t'($rtoi(sn * ay)), quat_t'($rtoi(sn * az)));
  endtask

  task automatic test_reset_quaternion();
    send_vertex('0, '0, '0);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(1));
    send_vertex(COORD_MIN, COORD_MAX, coord_t'(-1));
    wait_for_results();
  endtask

  // s = 0.5 scales by 1/4, so inputs of the form 4k+2 hit exact halves
  task automatic test_rounding_ties();
    write_quaternion(16'sd16384, '0, '0, '0);
    send_vertex(coord_t'(2), coord_t'(-2), coord_t'(6));
    send_vertex(coord_t'(-6), coord_t'(3), coord_t'(-3));
    send_vertex(coord_t'(1), coord_t'(-1), '0);
    wait_for_results();
  endtask

  task automatic test_axis_rotations();
    write_quaternion(16'sd23170, -16'sd23170, '0, '0);
    send_vertex(coord_t'(256), '0, '0);
    send_vertex('0, coord_t'(256), '0);
    send_vertex('0, '0, coord_t'(-256));
    wait_for_results();
    write_quaternion('0, '0, 16'sd32767, '0);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(12345));
    wait_for_results();
    write_quaternion('0, '0, '0, quat_t'(16'sh8000));
    send_vertex(COORD_MIN, COORD_MAX, coord_t'(-12345));
    wait_for_results();
  endtask

  // non-unit quaternions, |q|^2 near 4 or zero
  task automatic test_register_extremes();
    write_quaternion(quat_t'(16'sh8000), quat_t'(16'sh8000), quat_t'(16'sh8000),
                     quat_t'(16'sh8000));
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(coord_t'(100), coord_t'(-200), coord_t'(300));
    wait_for_results();
    write_quaternion(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
    send_vertex(coord_t'(-1), coord_t'(1), '0);
    wait_for_results();
    write_quaternion('0, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(-1));
    wait_for_results();
  endtask

  task automatic test_random_rotations();
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase != 3);
      if (phase % 2 == 0)
        write_random_rotation();
      else
        write_quaternion(quat_t'($urandom), quat_t'($urandom), quat_t'($urandom),
                         quat_t'($urandom));
      for (int n = 0; n < 150; n++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord());
        if (phase == 5 && n == 75)
          wait_for_results();
      end
      wait_for_results();
    end
    idle_on = 1'b1;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rotated_t want;
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected transaction: rx %0d ry %0d rz %0d", rx, ry, rz);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        check_field("rx", want.x, rx);
        check_field("ry", want.y, ry);
        check_field("rz", want.z, rz);
        check_field("clipped", want.clip, clipped);
      end
    end
  end

  always @(posedge clk)
    out_ready <= !idle_on || ($urandom_range(0, 99) >= 15);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_S;
    cfg_data = '0;
    in_valid = 1'b0;
    px = '0;
    py = '0;
    pz = '0;
    out_ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    rot_s = QUAT_S_RST;
    rot_x = '0;
    rot_y = '0;
    rot_z = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_quaternion();
    test_rounding_ties();
    test_axis_rotations();
    test_register_extremes();
    test_random_rotations();
    wait_for_results();
    repeat (NUM_STG * 4) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
